[rtl/tpms_pkg.sv]
// Shared constants and types of the periodic surface level-set evaluator.
`default_nettype none
package tpms_pkg;

	localparam int PHASE_BITS   = 20;
	localparam int QUARTER_BITS = PHASE_BITS - 2;
	localparam int FIELD_W      = 20;
	localparam int IN_COORD_W   = 12;
	localparam int CFG_W        = 20;
	localparam int CFG_IDX_W    = 2;

	localparam int COORD_BITS_DEF       = 12;
	localparam int TRIG_TABLE_DEPTH_DEF = 256;
	localparam int FRACTION_BITS_DEF    = 14;

	// pi/2 in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic signed [FIELD_W-1:0] OUT_MAX = 20'sh7FFFF;
	localparam logic signed [FIELD_W-1:0] OUT_MIN = -20'sh80000;

	typedef enum logic [2:0] {
		SURF_PRIMITIVE = 3'd0,
		SURF_GYROID    = 3'd1,
		SURF_DIAMOND   = 3'd2,
		SURF_IWP       = 3'd3,
		SURF_FKS       = 3'd4,
		SURF_FRD       = 3'd5,
		SURF_SPLIT_P   = 3'd6,
		SURF_LIDINOID  = 3'd7
	} surf_t;

	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd2;

	localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 20'd32768;

endpackage
`default_nettype wire

[rtl/tpms_level_set_evaluator.sv]
// Top level: pipelined level-set evaluator for eight triply periodic surfaces.
//
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         coord_x[11:0], coord_y[23:12], coord_z[35:24], zero pad to 40 bits
// m_axis    out        field_value[19:0] signed, zero pad to 24 bits
// cfg       in         cfg_index selects surface_type, level_offset or phase_step
//
// A word passes through seven register stages: phase multiply, table lookup,
// first products, second products, combine, divide-by-ten estimate and
// correction with saturation. One word enters per cycle while the output is not
// held back. The accepting edge loads the first stage, and the result is presented
// from the register of the correction stage.
// The sine table is constant logic built at elaboration; no clearing pass is needed.
// Reset clears the valid bits and sets the configuration registers to their
// reset values. Each stage holds its word while the next stage is full and
// stalled, and takes a new one as soon as its contents move on, so bubbles close up.
`default_nettype none
module tpms_level_set_evaluator
	import tpms_pkg::*;
#(
	parameter int COORD_BITS       = COORD_BITS_DEF,
	parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF,
	parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [39:0]          s_axis_tdata,   // coord_x, coord_y, coord_z
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [23:0]               m_axis_tdata,   // field_value
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int FB    = FRACTION_BITS;
	localparam int DEPTH = TRIG_TABLE_DEPTH;
	localparam int CU    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
	localparam int IW    = $clog2(DEPTH + 1);
	localparam int TW    = FB + 2;
	localparam int SW    = ((FB + 7 > 23) ? FB + 7 : 23) + 2;
	localparam int UW    = SW + 1;
	localparam int QW    = UW - 3;
	localparam int RS    = UW + 4;

	localparam logic [2*TW-1:0]      PR_HALF = (2*TW)'(64'd1 << (FB - 1));
	localparam logic signed [SW-1:0] ONE_Q   = SW'(64'd1 << FB);
	localparam logic [UW:0]          OFS5    = (UW+1)'(64'd10 * (64'd1 << (SW - 3)) + 64'd5);
	localparam logic [UW:0]          RECIP   = (UW+1)'((64'd1 << RS) / 10);
	localparam logic signed [SW:0]   QOFS    = (SW+1)'(64'd1 << (SW - 3));

	// Lookup slots: single and double angle of each axis.
	localparam int LX1 = 0, LX2 = 1, LY1 = 2, LY2 = 3, LZ1 = 4, LZ2 = 5;

	// ---------------- configuration registers ----------------
	surf_t                     surf_q;
	logic signed [FIELD_W-1:0] level_q;
	logic [PHASE_BITS-1:0]     step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_q  <= SURF_PRIMITIVE;
			level_q <= '0;
			step_q  <= PHASE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SURFACE_TYPE: surf_q  <= surf_t'(cfg_data[2:0]);
				REG_LEVEL_OFFSET: level_q <= signed'(cfg_data[FIELD_W-1:0]);
				REG_PHASE_STEP:   step_q  <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- quarter-wave sine table ----------------
	// Each entry is a Taylor series of sin(pi/2*k/DEPTH) in Q30, rounded to FB bits.
	logic [FB:0] sine_rom [DEPTH+1];

	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam longint unsigned H  = 64'd1 << 29;
		localparam longint unsigned X  = (HALF_PI_Q30 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
		localparam longint unsigned X2 = (X * X + H) >> 30;
		localparam longint unsigned T1  = ((X * X2 + H) >> 30) / 6;
		localparam longint unsigned T2  = ((T1 * X2 + H) >> 30) / 20;
		localparam longint unsigned T3  = ((T2 * X2 + H) >> 30) / 42;
		localparam longint unsigned T4  = ((T3 * X2 + H) >> 30) / 72;
		localparam longint unsigned T5  = ((T4 * X2 + H) >> 30) / 110;
		localparam longint unsigned T6  = ((T5 * X2 + H) >> 30) / 156;
		localparam longint unsigned T7  = ((T6 * X2 + H) >> 30) / 210;
		localparam longint unsigned T8  = ((T7 * X2 + H) >> 30) / 272;
		localparam longint unsigned T9  = ((T8 * X2 + H) >> 30) / 342;
		localparam longint unsigned T10 = ((T9 * X2 + H) >> 30) / 420;
		localparam longint unsigned T11 = ((T10 * X2 + H) >> 30) / 506;
		localparam longint unsigned T12 = ((T11 * X2 + H) >> 30) / 600;
		localparam longint unsigned POS = X + T2 + T4 + T6 + T8 + T10 + T12;
		localparam longint unsigned NEG = T1 + T3 + T5 + T7 + T9 + T11;
		localparam longint unsigned V   = (POS > NEG) ? POS - NEG : 64'd0;
		localparam longint unsigned VR  = (V + (64'd1 << (29 - FB))) >> (30 - FB);
		localparam longint unsigned VC  = (VR > (64'd1 << FB)) ? (64'd1 << FB) : VR;
		assign sine_rom[k] = VC[FB:0];
	end

	// Rounded fixed-point product, floor after adding half.
	function automatic logic signed [TW-1:0] qmul(input logic signed [TW-1:0] a,
		input logic signed [TW-1:0] b);
		logic signed [2*TW-1:0] p;
		p = a * b;
		p = p + signed'(PR_HALF);
		return p[FB +: TW];
	endfunction

	// ---------------- stage handshake ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || m_axis_tready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// ---------------- stage 1: axis phases ----------------
	logic [CU-1:0]            coord_c [3];
	logic [PHASE_BITS-1:0]    phase_s1 [3];

	assign coord_c[0] = s_axis_tdata[CU-1:0];
	assign coord_c[1] = s_axis_tdata[IN_COORD_W +: CU];
	assign coord_c[2] = s_axis_tdata[2*IN_COORD_W +: CU];

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int a = 0; a < 3; a++) begin
				phase_s1[a] <= PHASE_BITS'(PHASE_BITS'(coord_c[a]) * step_q);
			end
		end
	end

	// ---------------- stage 2: table lookups ----------------
	logic [PHASE_BITS-1:0]        lk_phase [6];
	logic signed [TW-1:0]         lk_sin [6];
	logic signed [TW-1:0]         lk_cos [6];
	logic signed [TW-1:0]         sn_s2 [6];
	logic signed [TW-1:0]         cs_s2 [6];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lk_phase[2*a]     = phase_s1[a];
			lk_phase[2*a + 1] = {phase_s1[a][PHASE_BITS-2:0], 1'b0};
		end
	end

	always_comb begin
		logic [QUARTER_BITS+IW-1:0] prod;
		logic [IW-1:0]              idx;
		logic signed [TW-1:0]       ea, eb;
		for (int l = 0; l < 6; l++) begin
			prod = (QUARTER_BITS+IW)'(lk_phase[l][QUARTER_BITS-1:0])
				* (QUARTER_BITS+IW)'(DEPTH);
			idx  = prod[QUARTER_BITS +: IW];
			ea   = signed'({1'b0, sine_rom[idx]});
			eb   = signed'({1'b0, sine_rom[IW'(DEPTH) - idx]});
			case (lk_phase[l][PHASE_BITS-1:QUARTER_BITS])
				2'd0: begin lk_sin[l] = ea;  lk_cos[l] = eb;  end
				2'd1: begin lk_sin[l] = eb;  lk_cos[l] = -ea; end
				2'd2: begin lk_sin[l] = -ea; lk_cos[l] = -eb; end
				default: begin lk_sin[l] = -eb; lk_cos[l] = ea; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sn_s2 <= lk_sin;
			cs_s2 <= lk_cos;
		end
	end

	// ---------------- stage 3: first products ----------------
	logic signed [TW-1:0] xs1, xc1, xs2, xc2, ys1, yc1, ys2, yc2, zs1, zc1, zs2, zc2;
	assign xs1 = sn_s2[LX1]; assign xc1 = cs_s2[LX1];
	assign xs2 = sn_s2[LX2]; assign xc2 = cs_s2[LX2];
	assign ys1 = sn_s2[LY1]; assign yc1 = cs_s2[LY1];
	assign ys2 = sn_s2[LY2]; assign yc2 = cs_s2[LY2];
	assign zs1 = sn_s2[LZ1]; assign zc1 = cs_s2[LZ1];
	assign zs2 = sn_s2[LZ2]; assign zc2 = cs_s2[LZ2];

	logic signed [TW-1:0] opa [4];
	logic signed [TW-1:0] opb [4];
	logic signed [TW-1:0] opt [4];
	logic                 triple_c;

	always_comb begin
		for (int m = 0; m < 4; m++) begin
			opa[m] = '0; opb[m] = '0; opt[m] = '0;
		end
		triple_c = 1'b0;
		unique case (surf_q)
			SURF_GYROID: begin
				opa[0] = xc1; opb[0] = ys1;
				opa[1] = yc1; opb[1] = zs1;
				opa[2] = zc1; opb[2] = xs1;
			end
			SURF_DIAMOND: begin
				triple_c = 1'b1;
				opa[0] = xs1; opb[0] = ys1; opt[0] = zs1;
				opa[1] = xs1; opb[1] = yc1; opt[1] = zc1;
				opa[2] = xc1; opb[2] = ys1; opt[2] = zc1;
				opa[3] = xc1; opb[3] = yc1; opt[3] = zs1;
			end
			SURF_IWP: begin
				opa[0] = xc1; opb[0] = yc1;
				opa[1] = yc1; opb[1] = zc1;
				opa[2] = zc1; opb[2] = xc1;
			end
			SURF_FKS: begin
				triple_c = 1'b1;
				opa[0] = xc2; opb[0] = ys1; opt[0] = zc1;
				opa[1] = xc1; opb[1] = yc2; opt[1] = zs1;
				opa[2] = xs1; opb[2] = yc1; opt[2] = zc2;
			end
			SURF_FRD: begin
				triple_c = 1'b1;
				opa[0] = xc1; opb[0] = yc1; opt[0] = zc1;
			end
			SURF_SPLIT_P: begin
				triple_c = 1'b1;
				opa[0] = xs2; opb[0] = zs1; opt[0] = yc1;
				opa[1] = ys2; opb[1] = xs1; opt[1] = zc1;
				opa[2] = zs2; opb[2] = ys1; opt[2] = xc1;
			end
			SURF_LIDINOID: begin
				triple_c = 1'b1;
				opa[0] = xs2; opb[0] = yc1; opt[0] = zs1;
				opa[1] = ys2; opb[1] = zc1; opt[1] = xs1;
				opa[2] = zs2; opb[2] = xc1; opt[2] = ys1;
			end
			default: ;
		endcase
	end

	logic signed [TW-1:0]   m_s3 [4];
	logic signed [TW-1:0]   t_s3 [4];
	logic signed [TW-1:0]   b_s3 [3];
	logic signed [TW+1:0]   c1sum_s3, c2sum_s3;
	logic                   triple_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int m = 0; m < 4; m++) begin
				m_s3[m] <= qmul(opa[m], opb[m]);
			end
			t_s3      <= opt;
			b_s3[0]   <= qmul(xc2, yc2);
			b_s3[1]   <= qmul(yc2, zc2);
			b_s3[2]   <= qmul(zc2, xc2);
			c1sum_s3  <= (TW+2)'(xc1) + (TW+2)'(yc1) + (TW+2)'(zc1);
			c2sum_s3  <= (TW+2)'(xc2) + (TW+2)'(yc2) + (TW+2)'(zc2);
			triple_s3 <= triple_c;
		end
	end

	// ---------------- stage 4: second products ----------------
	logic signed [TW-1:0]   q_s4 [4];
	logic signed [TW-1:0]   b_s4 [3];
	logic signed [TW+1:0]   c1sum_s4, c2sum_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int m = 0; m < 4; m++) begin
				q_s4[m] <= triple_s3 ? qmul(m_s3[m], t_s3[m]) : m_s3[m];
			end
			b_s4     <= b_s3;
			c1sum_s4 <= c1sum_s3;
			c2sum_s4 <= c2sum_s3;
		end
	end

	// ---------------- stage 5: combine per surface ----------------
	logic signed [SW-1:0] psum, bsum, c1x, c2x, lvx, t_c;
	logic                 tenth_c;

	assign psum = SW'(q_s4[0]) + SW'(q_s4[1]) + SW'(q_s4[2]) + SW'(q_s4[3]);
	assign bsum = SW'(b_s4[0]) + SW'(b_s4[1]) + SW'(b_s4[2]);
	assign c1x  = SW'(c1sum_s4);
	assign c2x  = SW'(c2sum_s4);
	assign lvx  = SW'(level_q);

	always_comb begin
		tenth_c = 1'b0;
		unique case (surf_q)
			SURF_PRIMITIVE: t_c = c1x - lvx;
			SURF_IWP:       t_c = (psum <<< 1) - c2x - lvx;
			SURF_FRD:       t_c = bsum - (psum <<< 2) - lvx;
			SURF_SPLIT_P: begin
				// Whole expression negated, level included, at ten times scale.
				tenth_c = 1'b1;
				t_c = (lvx <<< 3) + (lvx <<< 1) + (bsum <<< 1) + (c2x <<< 2)
					- ((psum <<< 3) + (psum <<< 1) + psum);
			end
			SURF_LIDINOID: begin
				tenth_c = 1'b1;
				t_c = ((psum - bsum - lvx) <<< 3) + ((psum - bsum - lvx) <<< 1)
					+ (ONE_Q <<< 1) + ONE_Q;
			end
			default:        t_c = psum - lvx;
		endcase
	end

	logic signed [SW-1:0] t_s5;
	logic                 tenth_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			t_s5     <= t_c;
			tenth_s5 <= tenth_c;
		end
	end

	// ---------------- stage 6: divide by ten, estimate ----------------
	// The sum is biased by a multiple of ten, plus five for rounding, to make it
	// positive, then multiplied by a reciprocal that never overestimates the quotient.
	logic [UW:0]        ubias_c;
	logic [2*UW:0]      qprod_c;
	logic [UW-1:0]      u_s6;
	logic [QW-1:0]      q0_s6;
	logic signed [SW-1:0] t_s6;
	logic               tenth_s6;

	assign ubias_c = (UW+1)'(t_s5) + OFS5;
	assign qprod_c = (2*UW+1)'(ubias_c[UW-1:0]) * (2*UW+1)'(RECIP);

	always_ff @(posedge clk) begin
		if (en6) begin
			u_s6     <= ubias_c[UW-1:0];
			q0_s6    <= qprod_c[RS +: QW];
			t_s6     <= t_s5;
			tenth_s6 <= tenth_s5;
		end
	end

	// ---------------- stage 7: correction and saturation ----------------
	logic [UW-1:0]        rem_c;
	logic signed [SW:0]   quot_c, res_c;
	logic signed [FIELD_W-1:0] sat_c;
	logic signed [FIELD_W-1:0] field_s7;

	assign rem_c  = u_s6 - ((UW'(q0_s6) << 3) + (UW'(q0_s6) << 1));
	assign quot_c = signed'((SW+1)'(q0_s6)) + ((rem_c >= UW'(10)) ? (SW+1)'(1) : (SW+1)'(0))
		- QOFS;
	assign res_c  = tenth_s6 ? quot_c : (SW+1)'(t_s6);

	always_comb begin
		if (res_c > (SW+1)'(OUT_MAX)) begin
			sat_c = OUT_MAX;
		end else if (res_c < (SW+1)'(OUT_MIN)) begin
			sat_c = OUT_MIN;
		end else begin
			sat_c = res_c[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			field_s7 <= sat_c;
		end
	end

	assign m_axis_tdata = {4'b0, field_s7};

	// ---------------- assertions ----------------
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output stage is empty");

	a_no_invented_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !v_s3 && !v_s4 && !v_s5 && !v_s6 && !v_s7) |=> !m_axis_tvalid)
		else $error("result word appeared from an empty pipeline");

	a_tenth_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && tenth_s6) |-> (rem_c < UW'(20)))
		else $error("divide-by-ten estimate off by more than one");

endmodule
`default_nettype wire
